@@ rtl/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants for the prime factor exponent block.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int PRIME_BITS    = 31;
    localparam int EXP_BITS      = 5;
    localparam int STATUS_BITS   = 2;
    localparam int COUNT_BITS    = 4;
    localparam int MAX_RESULTS   = 9;
    localparam int OUT_DATA_BITS = ((PRIME_BITS + EXP_BITS + 7) / 8) * 8;

    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_ODD     = 3;

    localparam logic [EXP_BITS-1:0] EXP_MAX = '1;

    localparam logic [STATUS_BITS-1:0] STATUS_PAIR = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ONE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO = 2'd2;

    typedef struct packed {
        logic load;
        logic special;
        logic start_div;
        logic take_quot;
        logic next_div;
        logic push_pair;
        logic push_tail;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic in_zero;
        logic in_one;
        logic div_done;
        logic rem_zero;
        logic d_gt_q;
        logic exp_nz;
        logic rem_gt1;
        logic k_full;
        logic can_push;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/pfe_divider.sv @@
// ----------------------------------------------------------------------------
// pfe_divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfe_divider #(
    parameter int DIVIDEND_BITS = 31,
    parameter int DIVISOR_BITS  = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic [DIVISOR_BITS-1:0]  remainder
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_BITS-1:0]  part_reg, part_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg, dsr_next;

    logic [DIVISOR_BITS:0] shifted;
    logic [DIVISOR_BITS:0] dsr_ext;
    logic                  ge;

    assign shifted = {part_reg, quo_reg[DIVIDEND_BITS-1]};
    assign dsr_ext = {1'b0, dsr_reg};
    assign ge      = (shifted >= dsr_ext);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        part_next = part_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIVIDEND_BITS);
            part_next = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            part_next = ge ? DIVISOR_BITS'(shifted - dsr_ext) : shifted[DIVISOR_BITS-1:0];
            quo_next  = {quo_reg[DIVIDEND_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = part_reg;

endmodule

@@ rtl/pfe_datapath.sv @@
// ----------------------------------------------------------------------------
// pfe_datapath
// Remainder, trial divisor, exponent counter, pending result and output
// register, driven by controller commands.
// ----------------------------------------------------------------------------
module pfe_datapath #(
    parameter int VALUE_BITS = 31
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [VALUE_BITS-1:0]            number,
    input  pfe_pkg::cmd_t                    cmd,
    output pfe_pkg::stat_t                   stat,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [pfe_pkg::PRIME_BITS-1:0]   out_prime,
    output logic [pfe_pkg::EXP_BITS-1:0]     out_exp,
    output logic [pfe_pkg::STATUS_BITS-1:0]  out_status,
    output logic                             out_last
);

    localparam int DIV_BITS  = (VALUE_BITS + 1) / 2 + 1;
    localparam int WIDE_BITS = (VALUE_BITS > pfe_pkg::PRIME_BITS) ? VALUE_BITS
                                                                  : pfe_pkg::PRIME_BITS;

    logic [VALUE_BITS-1:0]              rem_reg, rem_next;
    logic [DIV_BITS-1:0]                div_reg, div_next;
    logic [pfe_pkg::EXP_BITS-1:0]       exp_reg, exp_next;
    logic [pfe_pkg::COUNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [pfe_pkg::PRIME_BITS-1:0]     pend_prime_reg, pend_prime_next;
    logic [pfe_pkg::EXP_BITS-1:0]       pend_exp_reg, pend_exp_next;
    logic [pfe_pkg::STATUS_BITS-1:0]    special_reg, special_next;
    logic                               out_valid_reg, out_valid_next;
    logic [pfe_pkg::PRIME_BITS-1:0]     out_prime_reg, out_prime_next;
    logic [pfe_pkg::EXP_BITS-1:0]       out_exp_reg, out_exp_next;
    logic [pfe_pkg::STATUS_BITS-1:0]    out_status_reg, out_status_next;
    logic                               out_last_reg, out_last_next;

    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [DIV_BITS-1:0]   div_rem;
    logic [WIDE_BITS-1:0]  rem_wide;
    logic [WIDE_BITS-1:0]  div_wide;
    logic                  k_full;
    logic                  out_free;
    logic                  push;

    pfe_divider #(
        .DIVIDEND_BITS (VALUE_BITS),
        .DIVISOR_BITS  (DIV_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_div),
        .dividend  (rem_next),
        .divisor   (div_next),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign rem_wide = WIDE_BITS'(rem_reg);
    assign div_wide = WIDE_BITS'(div_reg);
    assign k_full   = (cnt_reg >= pfe_pkg::COUNT_BITS'(pfe_pkg::MAX_RESULTS));
    assign out_free = !out_valid_reg || out_ready;
    assign push     = (cmd.push_pair || cmd.push_tail) && !k_full;

    always_comb
    begin
        stat.in_zero  = (number == '0);
        stat.in_one   = (number == VALUE_BITS'(1));
        stat.div_done = div_done;
        stat.rem_zero = (div_rem == '0);
        stat.d_gt_q   = (VALUE_BITS'(div_reg) > div_quo);
        stat.exp_nz   = (exp_reg != '0);
        stat.rem_gt1  = (rem_reg > VALUE_BITS'(1));
        stat.k_full   = k_full;
        stat.can_push = k_full || !pend_valid_reg || out_free;
        stat.out_free = out_free;
    end

    always_comb
    begin
        rem_next        = rem_reg;
        div_next        = div_reg;
        exp_next        = exp_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_prime_next = pend_prime_reg;
        pend_exp_next   = pend_exp_reg;
        special_next    = special_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_prime_next  = out_prime_reg;
        out_exp_next    = out_exp_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (cmd.load)
        begin
            rem_next        = number;
            div_next        = DIV_BITS'(pfe_pkg::FIRST_DIVISOR);
            exp_next        = '0;
            cnt_next        = '0;
            pend_valid_next = 1'b0;
            special_next    = (number == '0) ? pfe_pkg::STATUS_ZERO : pfe_pkg::STATUS_ONE;
        end
        if (cmd.take_quot)
        begin
            rem_next = div_quo;
            exp_next = (exp_reg == pfe_pkg::EXP_MAX) ? exp_reg : exp_reg + 1'b1;
        end
        if (cmd.next_div)
        begin
            div_next = (div_reg == DIV_BITS'(pfe_pkg::FIRST_DIVISOR))
                       ? DIV_BITS'(pfe_pkg::FIRST_ODD)
                       : div_reg + DIV_BITS'(2);
            exp_next = '0;
        end
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_prime_next  = pend_prime_reg;
                out_exp_next    = pend_exp_reg;
                out_status_next = pfe_pkg::STATUS_PAIR;
                out_last_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_prime_next = cmd.push_pair ? div_wide[pfe_pkg::PRIME_BITS-1:0]
                                            : rem_wide[pfe_pkg::PRIME_BITS-1:0];
            pend_exp_next   = cmd.push_pair ? exp_reg : pfe_pkg::EXP_BITS'(1);
            cnt_next        = cnt_reg + 1'b1;
        end
        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            out_prime_next  = pend_prime_reg;
            out_exp_next    = pend_exp_reg;
            out_status_next = pfe_pkg::STATUS_PAIR;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (cmd.special)
        begin
            out_valid_next  = 1'b1;
            out_prime_next  = '0;
            out_exp_next    = '0;
            out_status_next = special_reg;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            div_reg        <= DIV_BITS'(pfe_pkg::FIRST_DIVISOR);
            exp_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rem_reg        <= rem_next;
            div_reg        <= div_next;
            exp_reg        <= exp_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_prime_reg <= pend_prime_next;
        pend_exp_reg   <= pend_exp_next;
        special_reg    <= special_next;
        out_prime_reg  <= out_prime_next;
        out_exp_reg    <= out_exp_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_prime  = out_prime_reg;
    assign out_exp    = out_exp_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

@@ rtl/pfe_controller.sv @@
// ----------------------------------------------------------------------------
// pfe_controller
// State machine that sequences trial divisions and result emission.
// ----------------------------------------------------------------------------
module pfe_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pfe_pkg::stat_t stat,
    output pfe_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPECIAL,
        ST_DIV,
        ST_DECIDE,
        ST_FINAL,
        ST_FLUSH
    } state_t;

    typedef enum logic {
        MODE_STRIP,
        MODE_CHECK
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        mode_next  = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.in_zero || stat.in_one)
                    begin
                        state_next = ST_SPECIAL;
                    end
                    else
                    begin
                        cmd.start_div = 1'b1;
                        mode_next     = MODE_STRIP;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_SPECIAL:
            begin
                if (stat.out_free)
                begin
                    cmd.special = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (mode_reg == MODE_CHECK)
                begin
                    if (stat.d_gt_q)
                    begin
                        state_next = ST_FINAL;
                    end
                    else if (stat.rem_zero)
                    begin
                        cmd.take_quot = 1'b1;
                        cmd.start_div = 1'b1;
                        mode_next     = MODE_STRIP;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.next_div  = 1'b1;
                        cmd.start_div = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
                else
                begin
                    if (stat.rem_zero)
                    begin
                        cmd.take_quot = 1'b1;
                        cmd.start_div = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else if (!stat.exp_nz || stat.can_push)
                    begin
                        cmd.push_pair = stat.exp_nz;
                        cmd.next_div  = 1'b1;
                        cmd.start_div = 1'b1;
                        mode_next     = MODE_CHECK;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_FINAL:
            begin
                if (stat.rem_gt1 && !stat.k_full)
                begin
                    if (stat.can_push)
                    begin
                        cmd.push_tail = 1'b1;
                        state_next    = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_STRIP;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

@@ rtl/prime_factor_exponents.sv @@
// ----------------------------------------------------------------------------
// prime_factor_exponents
// Trial-division prime factorization that emits each distinct prime with
// its exponent, in ascending order.
//
// Channel   Direction  tdata                          tuser    tlast
// s_axis    in         number                         -        -
// m_axis    out        prime, exponent                status   last
//
// Each trial division runs on a shared restoring divider that takes one
// quotient bit per cycle. Reset needs no clearing pass. A stalled output
// holds the block when a result must move into the output register while
// that register still holds an earlier result.
// ----------------------------------------------------------------------------
module prime_factor_exponents #(
    parameter int VALUE_BITS = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: number.
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: prime, exponent, zero fill.
    output logic [pfe_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // Fields from bit 0: status.
    output logic [pfe_pkg::STATUS_BITS-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int FILL_BITS = pfe_pkg::OUT_DATA_BITS - pfe_pkg::PRIME_BITS
                               - pfe_pkg::EXP_BITS;

    pfe_pkg::cmd_t  cmd;
    pfe_pkg::stat_t stat;

    logic [pfe_pkg::PRIME_BITS-1:0] out_prime;
    logic [pfe_pkg::EXP_BITS-1:0]   out_exp;
    logic                           in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    pfe_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_accept),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfe_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .number     (s_axis_tdata[VALUE_BITS-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_prime  (out_prime),
        .out_exp    (out_exp),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{FILL_BITS{1'b0}}, out_exp, out_prime};

    // A result for an input of 0 or 1 is the only result of its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != pfe_pkg::STATUS_PAIR)
        |-> m_axis_tlast && (out_prime == '0) && (out_exp == '0))
    else $error("special result is not a lone zero result");

    // Every factor result carries a nonzero exponent.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == pfe_pkg::STATUS_PAIR) |-> (out_exp != '0))
    else $error("factor result with zero exponent");

    // An accepted input keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
    else $error("input accepted while previous input still in progress");

    // No command to start a division arrives while the controller waits on one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |=> !cmd.start_div)
    else $error("back-to-back divider starts");

endmodule

@@ tb/factor_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// factor_checker
// Watches both stream channels of the prime factor exponent block. Every
// number taken on the input is factored here by trial division, and the
// resulting prime/exponent list is queued. Each output transaction is
// compared field by field with the oldest queued result. Mismatches, results
// that arrive with nothing queued and the number of results still owed are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module factor_checker #(
    parameter int VALUE_BITS = 31,
    parameter int IN_BITS    = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // Fields from bit 0: number.
    input  logic [IN_BITS-1:0]                s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: prime, exponent, zero fill.
    input  logic [pfe_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // Fields from bit 0: status.
    input  logic [pfe_pkg::STATUS_BITS-1:0]   m_axis_tuser,
    input  logic                              m_axis_tlast,
    output int                                errors,
    output int                                pending,
    output int                                numbers_seen,
    output int                                factors_seen
);

    typedef struct packed {
        logic [pfe_pkg::PRIME_BITS-1:0]  prime;
        logic [pfe_pkg::EXP_BITS-1:0]    exponent;
        logic [pfe_pkg::STATUS_BITS-1:0] status;
        logic                            last;
    } factor_t;

    factor_t expected_factors[$];

    initial
    begin
        errors       = 0;
        pending      = 0;
        numbers_seen = 0;
        factors_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic factor_t make_factor(input longint unsigned prime,
                                            input longint unsigned power,
                                            input logic [pfe_pkg::STATUS_BITS-1:0] status);
        factor_t f;
        f.prime    = prime[pfe_pkg::PRIME_BITS-1:0];
        f.exponent = (power > pfe_pkg::EXP_MAX) ? pfe_pkg::EXP_MAX
                                                : power[pfe_pkg::EXP_BITS-1:0];
        f.status   = status;
        f.last     = 1'b0;
        return f;
    endfunction

    task automatic factorize(input logic [VALUE_BITS-1:0] number);
        factor_t         found[$];
        longint unsigned rest;
        longint unsigned divisor;
        longint unsigned power;
        rest = number;
        if (rest == 0)
        begin
            found.insert(found.size(), make_factor(0, 0, pfe_pkg::STATUS_ZERO));
        end
        else if (rest == 1)
        begin
            found.insert(found.size(), make_factor(0, 0, pfe_pkg::STATUS_ONE));
        end
        else
        begin
            divisor = pfe_pkg::FIRST_DIVISOR;
            while (1)
            begin
                power = 0;
                while (rest % divisor == 0)
                begin
                    rest = rest / divisor;
                    power++;
                end
                if (power != 0 && found.size() < pfe_pkg::MAX_RESULTS)
                    found.insert(found.size(),
                                 make_factor(divisor, power, pfe_pkg::STATUS_PAIR));
                divisor = (divisor == pfe_pkg::FIRST_DIVISOR) ? pfe_pkg::FIRST_ODD
                                                              : divisor + 2;
                if (!(rest > 1 && divisor <= rest / divisor))
                    break;
            end
            // Whatever is left above one after the square bound is prime.
            if (rest > 1 && found.size() < pfe_pkg::MAX_RESULTS)
                found.insert(found.size(), make_factor(rest, 1, pfe_pkg::STATUS_PAIR));
        end
        found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            expected_factors.insert(expected_factors.size(), found[i]);
    endtask

    always @(posedge clk)
    begin : monitor
        factor_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                factorize(s_axis_tdata[VALUE_BITS-1:0]);
                numbers_seen++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                factors_seen++;
                if (expected_factors.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %0d: prime %0d status %0d",
                                              factors_seen,
                                              m_axis_tdata[pfe_pkg::PRIME_BITS-1:0],
                                              m_axis_tuser));
                end
                else
                begin
                    want = expected_factors.pop_front();
                    if (m_axis_tdata[pfe_pkg::PRIME_BITS-1:0] !== want.prime)
                        report_mismatch($sformatf("result %0d prime: expected %0d, got %0d",
                                                  factors_seen, want.prime,
                                                  m_axis_tdata[pfe_pkg::PRIME_BITS-1:0]));
                    if (m_axis_tdata[pfe_pkg::PRIME_BITS +: pfe_pkg::EXP_BITS]
                        !== want.exponent)
                        report_mismatch($sformatf(
                            "result %0d exponent: expected %0d, got %0d",
                            factors_seen, want.exponent,
                            m_axis_tdata[pfe_pkg::PRIME_BITS +: pfe_pkg::EXP_BITS]));
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                                  factors_seen, want.status, m_axis_tuser));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("result %0d last: expected %0d, got %0d",
                                                  factors_seen, want.last, m_axis_tlast));
                end
            end
            pending <= expected_factors.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the prime factor exponent block. A directed set
// covers zero, one, prime powers up to 2^30, a product of
// nine primes and the largest input, which is prime. Random numbers follow,
// mostly small or built from small factors so that trial division stays
// short. Both sides idle at random in two of three phases; the output is
// held off for a long stretch once so that the block backs up its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int              VALUE_BITS     = 31;
    localparam int              IN_BITS        = ((VALUE_BITS + 7) / 8) * 8;
    localparam longint unsigned MAX_NUMBER     = (64'd1 << VALUE_BITS) - 1;
    localparam longint          CYCLE_LIMIT    = 10_000_000;
    localparam int              HOLD_CYCLES    = 600;
    localparam int              SETTLE_CYCLES  = 100;
    localparam int              PHASE_NUMBERS  = 34;
    localparam int              WIDE_SLOT      = 20;

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [IN_BITS-1:0]                s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [pfe_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [pfe_pkg::STATUS_BITS-1:0]   m_axis_tuser;
    logic                              m_axis_tlast;

    int     chk_errors;
    int     chk_pending;
    int     chk_numbers;
    int     chk_factors;
    int     send_idle_pct = 34;
    int     recv_idle_pct = 71;
    logic   long_hold     = 1'b0;
    int     hold_left     = 0;
    logic   hold_taken    = 1'b0;
    longint cycles        = 0;

    logic [VALUE_BITS-1:0] corner_numbers[$] = '{
        0, 1, 0, 2, 3, 4, 9, 49, 360, 10403, 65536, 223092870, 1073741824,
        1162261467, 1431655765, 2147483646, 2147483647, 1, 1
    };

    prime_factor_exponents #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    factor_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .errors       (chk_errors),
        .pending      (chk_pending),
        .numbers_seen (chk_numbers),
        .factors_seen (chk_factors)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, chk_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The long hold-off starts once when requested and is counted here.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (long_hold && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [VALUE_BITS-1:0] smooth_number(input int factors);
        longint unsigned value;
        longint unsigned scale;
        value = 1;
        repeat (factors)
        begin
            scale = $urandom_range(37, 2);
            if (value * scale <= MAX_NUMBER)
                value = value * scale;
        end
        return value[VALUE_BITS-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_number();
        int unsigned     pick;
        longint unsigned value;
        pick = $urandom_range(99);
        if (pick < 8)
            value = $urandom_range(1);
        else if (pick < 45)
            value = $urandom_range(65535);
        else if (pick < 85)
            value = smooth_number($urandom_range(40, 1));
        else
        begin
            value = smooth_number($urandom_range(6, 1)) * $urandom_range(40000, 2);
            if (value > MAX_NUMBER)
                value = $urandom_range(40000, 2);
        end
        return value[VALUE_BITS-1:0];
    endfunction

    task automatic send_number(input logic [VALUE_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'(value);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_numbers[i])
            send_number(corner_numbers[i]);
        repeat (PHASE_NUMBERS - 1)
            send_number(random_number());

        send_idle_pct = 71;
        recv_idle_pct <= 34;
        repeat (PHASE_NUMBERS - 1)
            send_number(random_number());

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        long_hold     <= 1'b1;
        for (int i = 0; i < PHASE_NUMBERS; i++)
        begin
            if (i == WIDE_SLOT)
                send_number(VALUE_BITS'($urandom));
            else
                send_number(random_number());
        end

        drain();

        $display("Factored %0d numbers into %0d results: zero, one, prime powers,",
                 chk_numbers, chk_factors);
        $display("a nine-prime product, the largest prime, and random values under %0d-cycle hold.",
                 HOLD_CYCLES);
        if (chk_errors == 0 && chk_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pfe_pkg.sv
rtl/pfe_divider.sv
rtl/pfe_datapath.sv
rtl/pfe_controller.sv
rtl/prime_factor_exponents.sv
tb/factor_checker.sv
tb/tb_top.sv
